// ===== rtl/core/fsrc_pkg.sv =====
// Shared types and constants of the fan speed ramp controller.
`timescale 1ns / 1ps

package fsrc_pkg;

    localparam int unsigned DIV_STEPS = 7;
    localparam logic [6:0]  MANUAL_CAP = 7'd100;

    localparam logic [1:0] FUNC_OFF = 2'd0;
    localparam logic [1:0] FUNC_ON  = 2'd1;

    typedef enum logic [2:0] {
        CFG_TEMP_THRESHOLD = 3'd0,
        CFG_TEMP_MAX_ALARM = 3'd1,
        CFG_HUM_THRESHOLD  = 3'd2,
        CFG_HUM_MAX_ALARM  = 3'd3,
        CFG_SPEED_MIN      = 3'd4,
        CFG_SPEED_MAX      = 3'd5,
        CFG_DELTA_MIN      = 3'd6,
        CFG_SAFETY_SPEED   = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CAUSE_MANUAL   = 3'd0,
        CAUSE_SAFETY   = 3'd1,
        CAUSE_COMBINED = 3'd2,
        CAUSE_TEMP     = 3'd3,
        CAUSE_HUM      = 3'd4,
        CAUSE_MINIMUM  = 3'd5
    } cause_t;

    typedef enum logic [1:0] {
        EVAL_DROP    = 2'd0,
        EVAL_NONRAMP = 2'd1,
        EVAL_RAMP    = 2'd2
    } eval_kind_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         manual_speed;
        logic [31:0]        now_ms;
        logic               recipe_active;
        logic               sensors_valid;
        logic               has_external;
        logic signed [11:0] temperature;
        logic [9:0]         humidity;
        logic signed [11:0] temp_delta;
        logic [15:0]        fan_rpm;
    } in_item_t;

    typedef struct packed {
        logic [6:0] speed_percent;
        logic       relay_on;
        cause_t     cause;
        logic       stalled;
        logic [6:0] speed_from_temp;
        logic [6:0] speed_from_hum;
        logic       temp_ramp_active;
        logic       telemetry_updated;
    } out_item_t;

    typedef struct packed {
        logic take;
        logic eval;
        logic div_step;
        logic div_swap;
        logic fin;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        eval_kind_t kind;
    } dp_status_t;

endpackage

// ===== rtl/core/fsrc_ctrl.sv =====
// Sequencing state machine of the fan speed ramp controller.
`timescale 1ns / 1ps

module fsrc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  fsrc_pkg::dp_status_t status,
    output fsrc_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV_T,
        S_SWAP,
        S_DIV_H,
        S_FIN,
        S_DONE
    } state_t;

    localparam logic [2:0] LAST_STEP = 3'(fsrc_pkg::DIV_STEPS - 1);

    state_t     state_reg;
    logic [2:0] cnt_reg;
    logic       m_valid_reg;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.take     = (state_reg == S_IDLE) && s_valid;
        cmd.eval     = (state_reg == S_EVAL);
        cmd.div_step = (state_reg == S_DIV_T) || (state_reg == S_DIV_H);
        cmd.div_swap = (state_reg == S_SWAP);
        cmd.fin      = (state_reg == S_FIN);
        cmd.load_out = (state_reg == S_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == S_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    cnt_reg <= '0;
                    case (status.kind)
                        fsrc_pkg::EVAL_NONRAMP: state_reg <= S_DONE;
                        fsrc_pkg::EVAL_RAMP:    state_reg <= S_DIV_T;
                        default:                state_reg <= S_IDLE;
                    endcase
                end
                S_DIV_T: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == LAST_STEP) begin
                        state_reg <= S_SWAP;
                    end
                end
                S_SWAP: begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV_H;
                end
                S_DIV_H: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == LAST_STEP) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/fsrc_dp.sv =====
// Datapath of the fan speed ramp controller: settings, timer, ramps, shared divider.
`timescale 1ns / 1ps

module fsrc_dp #(
    parameter int unsigned UPDATE_INTERVAL_MS = 5000,
    parameter int unsigned STALL_RPM          = 300
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fsrc_pkg::in_item_t   s_item,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [11:0]          cfg_data,
    input  fsrc_pkg::dp_cmd_t    cmd,
    output fsrc_pkg::dp_status_t status,
    output fsrc_pkg::out_item_t  m_item
);

    // settings
    logic signed [11:0] temp_thr_reg;
    logic signed [11:0] temp_max_reg;
    logic [9:0]         hum_thr_reg;
    logic [9:0]         hum_max_reg;
    logic [6:0]         spd_min_reg;
    logic [6:0]         spd_max_reg;
    logic signed [11:0] delta_min_reg;
    logic [6:0]         safety_reg;

    fsrc_pkg::in_item_t  in_reg;
    fsrc_pkg::out_item_t res_reg;
    fsrc_pkg::out_item_t res_next;
    fsrc_pkg::out_item_t res_fin;
    fsrc_pkg::out_item_t out_reg;
    logic [31:0]         last_reg;

    // divider
    logic [11:0] rem_reg;
    logic [6:0]  quo_reg;
    logic [11:0] dvs_reg;
    logic [18:0] hum_p_reg;
    logic [11:0] hum_r_reg;
    logic [6:0]  q_t_reg;

    logic        auto_mode;
    logic [31:0] elapsed;
    logic [6:0]  manual_cap;
    logic        spd_up;
    logic [6:0]  spd_diff;
    logic [11:0] num_t;
    logic [11:0] range_t;
    logic [9:0]  num_h;
    logic [9:0]  range_h;
    logic [18:0] prod_t;
    logic [16:0] prod_h;
    logic [12:0] trial;
    logic        trial_ge;
    logic [12:0] trial_sub;
    logic        temp_on;
    logic [6:0]  st;
    logic [6:0]  sh;
    logic [6:0]  tgt;
    logic [6:0]  tgt_lo;
    fsrc_pkg::cause_t cause;

    function automatic logic [6:0] ramp_mid(input logic up, input logic [6:0] smin,
                                            input logic [6:0] q);
        return up ? smin + q : smin - q;
    endfunction

    function automatic fsrc_pkg::out_item_t make_res(input logic [6:0] spd,
                                                     input fsrc_pkg::cause_t cs,
                                                     input logic [15:0] rpm);
        fsrc_pkg::out_item_t r;
        r                   = '0;
        r.speed_percent     = spd;
        r.relay_on          = (spd != 7'd0);
        r.cause             = cs;
        r.stalled           = (32'(rpm) < STALL_RPM) && (spd != 7'd0);
        return r;
    endfunction

    // mode decision
    assign elapsed    = in_reg.now_ms - last_reg;
    assign manual_cap = ({1'b0, in_reg.manual_speed} > {2'b00, fsrc_pkg::MANUAL_CAP})
                        ? fsrc_pkg::MANUAL_CAP : in_reg.manual_speed[6:0];

    always_comb begin
        auto_mode   = 1'b0;
        status.kind = fsrc_pkg::EVAL_NONRAMP;
        res_next    = make_res(7'd0, fsrc_pkg::CAUSE_MANUAL, in_reg.fan_rpm);
        case (in_reg.func)
            fsrc_pkg::FUNC_OFF: begin
                res_next = make_res(7'd0, fsrc_pkg::CAUSE_MANUAL, in_reg.fan_rpm);
            end
            fsrc_pkg::FUNC_ON: begin
                res_next = make_res(manual_cap, fsrc_pkg::CAUSE_MANUAL, in_reg.fan_rpm);
            end
            default: begin
                auto_mode = 1'b1;
                if (elapsed < UPDATE_INTERVAL_MS) begin
                    status.kind = fsrc_pkg::EVAL_DROP;
                end else if (!in_reg.recipe_active || !in_reg.sensors_valid) begin
                    res_next = make_res(safety_reg, fsrc_pkg::CAUSE_SAFETY, in_reg.fan_rpm);
                end else begin
                    status.kind = fsrc_pkg::EVAL_RAMP;
                end
            end
        endcase
    end

    // ramp operands
    assign spd_up   = (spd_max_reg >= spd_min_reg);
    assign spd_diff = spd_up ? spd_max_reg - spd_min_reg : spd_min_reg - spd_max_reg;
    assign num_t    = 12'(in_reg.temperature - temp_thr_reg);
    assign range_t  = 12'(temp_max_reg - temp_thr_reg);
    assign num_h    = in_reg.humidity - hum_thr_reg;
    assign range_h  = hum_max_reg - hum_thr_reg;
    assign prod_t   = num_t * spd_diff;
    assign prod_h   = num_h * spd_diff;

    // one restoring step; quotient fits in seven bits inside the ramp
    assign trial     = {rem_reg, quo_reg[6]};
    assign trial_ge  = (trial >= {1'b0, dvs_reg});
    assign trial_sub = trial - {1'b0, dvs_reg};

    // final selection
    assign temp_on = (in_reg.temperature >= temp_thr_reg) &&
                     (!in_reg.has_external || (in_reg.temp_delta > delta_min_reg));

    always_comb begin
        if (!temp_on) begin
            st = 7'd0;
        end else if (in_reg.temperature >= temp_max_reg) begin
            st = spd_max_reg;
        end else begin
            st = ramp_mid(spd_up, spd_min_reg, q_t_reg);
        end
        if (in_reg.humidity < hum_thr_reg) begin
            sh = 7'd0;
        end else if (in_reg.humidity >= hum_max_reg) begin
            sh = spd_max_reg;
        end else begin
            sh = ramp_mid(spd_up, spd_min_reg, quo_reg);
        end
        tgt_lo = (st > sh) ? st : sh;
        if (tgt_lo < spd_min_reg) begin
            tgt_lo = spd_min_reg;
        end
        tgt = (tgt_lo > spd_max_reg) ? spd_max_reg : tgt_lo;
        if ((st != 7'd0) && (sh != 7'd0)) begin
            cause = fsrc_pkg::CAUSE_COMBINED;
        end else if (st != 7'd0) begin
            cause = fsrc_pkg::CAUSE_TEMP;
        end else if (sh != 7'd0) begin
            cause = fsrc_pkg::CAUSE_HUM;
        end else begin
            cause = fsrc_pkg::CAUSE_MINIMUM;
        end
    end

    // ramp result with fresh telemetry
    always_comb begin
        res_fin                   = make_res(tgt, cause, in_reg.fan_rpm);
        res_fin.speed_from_temp   = st;
        res_fin.speed_from_hum    = sh;
        res_fin.temp_ramp_active  = temp_on;
        res_fin.telemetry_updated = 1'b1;
    end

    // settings and timer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_thr_reg  <= 12'sd250;
            temp_max_reg  <= 12'sd350;
            hum_thr_reg   <= 10'd700;
            hum_max_reg   <= 10'd900;
            spd_min_reg   <= 7'd20;
            spd_max_reg   <= 7'd100;
            delta_min_reg <= 12'sd20;
            safety_reg    <= 7'd30;
            last_reg      <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    fsrc_pkg::CFG_TEMP_THRESHOLD: temp_thr_reg  <= cfg_data;
                    fsrc_pkg::CFG_TEMP_MAX_ALARM: temp_max_reg  <= cfg_data;
                    fsrc_pkg::CFG_HUM_THRESHOLD:  hum_thr_reg   <= cfg_data[9:0];
                    fsrc_pkg::CFG_HUM_MAX_ALARM:  hum_max_reg   <= cfg_data[9:0];
                    fsrc_pkg::CFG_SPEED_MIN:      spd_min_reg   <= cfg_data[6:0];
                    fsrc_pkg::CFG_SPEED_MAX:      spd_max_reg   <= cfg_data[6:0];
                    fsrc_pkg::CFG_DELTA_MIN:      delta_min_reg <= cfg_data;
                    fsrc_pkg::CFG_SAFETY_SPEED:   safety_reg    <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (cmd.eval && auto_mode && (status.kind != fsrc_pkg::EVAL_DROP)) begin
                last_reg <= in_reg.now_ms;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            in_reg <= s_item;
        end
        if (cmd.eval) begin
            res_reg   <= res_next;
            rem_reg   <= prod_t[18:7];
            quo_reg   <= prod_t[6:0];
            dvs_reg   <= range_t;
            hum_p_reg <= {2'b00, prod_h};
            hum_r_reg <= {2'b00, range_h};
        end
        if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_sub[11:0] : trial[11:0];
            quo_reg <= {quo_reg[5:0], trial_ge};
        end
        if (cmd.div_swap) begin
            q_t_reg <= quo_reg;
            rem_reg <= hum_p_reg[18:7];
            quo_reg <= hum_p_reg[6:0];
            dvs_reg <= hum_r_reg;
        end
        if (cmd.fin) begin
            res_reg <= res_fin;
        end
        if (cmd.load_out) begin
            out_reg <= res_reg;
        end
    end

    assign m_item = out_reg;

endmodule

// ===== rtl/core/fan_speed_ramp_controller_unit.sv =====
// Top level of the fan speed ramp controller: FSM, datapath, ports and checks.
`timescale 1ns / 1ps
// Path: off, manual and safety beats go from evaluate straight to the output hand-off;
// automatic ramp beats first make two runs of the shared serial divider, then finish.
// Flow: one beat in flight; the next can be taken the cycle after the result moves to
// the output register, which waits while the output is held; automatic beats dropped
// by the update timer go from evaluate straight back to idle.
// Reset: synchronous, active-low aresetn; settings return to defaults, timestamp to 0.

module fan_speed_ramp_controller_unit #(
    parameter int unsigned UPDATE_INTERVAL_MS = 5000,
    parameter int unsigned STALL_RPM          = 300
) (
    input  logic                aclk,
    input  logic                aresetn,
    // evaluation requests
    input  logic                s_valid,
    output logic                s_ready,
    input  fsrc_pkg::in_item_t  s_item,
    // results
    output logic                m_valid,
    input  logic                m_ready,
    output fsrc_pkg::out_item_t m_item,
    // settings write port
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [11:0]         cfg_data
);

    fsrc_pkg::dp_cmd_t    cmd;
    fsrc_pkg::dp_status_t status;

    // Settings are single registers, so a write is always accepted.
    assign cfg_ready = 1'b1;

    // Controller: walks each beat through evaluate, then (ramp beats only) two divisions and
    // finish, then (all but dropped beats) hand-off to the output register; owns the output valid flag.
    fsrc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: holds settings and the last automatic timestamp, decides the
    // mode, forms the ramp products and divides them one quotient bit a cycle.
    fsrc_dp #(
        .UPDATE_INTERVAL_MS (UPDATE_INTERVAL_MS),
        .STALL_RPM          (STALL_RPM)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_item    (m_item)
    );

`ifndef SYNTHESIS
    // Only one beat is worked on at a time: taking a beat closes the input.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a beat is in flight");

    // Relay drive follows the commanded speed.
    a_relay_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.relay_on == (m_item.speed_percent != 7'd0)))
        else $error("relay drive disagrees with speed");

    // Fresh telemetry only comes from the ramp path.
    a_telemetry_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.telemetry_updated) |->
        (m_item.cause != fsrc_pkg::CAUSE_MANUAL && m_item.cause != fsrc_pkg::CAUSE_SAFETY))
        else $error("telemetry flagged on a non-ramp result");

    // Manual and off results never exceed the manual cap.
    a_manual_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.cause == fsrc_pkg::CAUSE_MANUAL) |->
        (m_item.speed_percent <= fsrc_pkg::MANUAL_CAP))
        else $error("manual speed above cap");
`endif

endmodule

// ===== dv/fan_speed_ramp_controller_unit_tb.sv =====
// Self-checking testbench of the fan speed ramp controller: directed cases, then random traffic.
`timescale 1ns / 1ps

module fan_speed_ramp_controller_unit_tb;

    localparam int unsigned EVAL_INTERVAL_MS = 5000;
    localparam int unsigned STALL_LIMIT_RPM  = 300;
    // leave margin for a dropped beat still in flight
    localparam int          SETTLE_CYCLES    = 24;
    localparam int          CYCLE_LIMIT      = 600000;
    localparam logic [1:0]  FUNC_AUTO        = 2'd2;
    localparam logic [1:0]  FUNC_AUTO_ALT    = 2'd3;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    fsrc_pkg::in_item_t  s_item;
    logic                m_valid;
    logic                m_ready;
    fsrc_pkg::out_item_t m_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [11:0]         cfg_data;

    // shadow copy of the settings and the evaluation timestamp
    int          thr_temp;
    int          alarm_temp;
    int          thr_hum;
    int          alarm_hum;
    int          spd_min;
    int          spd_max;
    int          delta_floor;
    int          spd_safety;
    logic [31:0] last_eval_ms;

    // timestamp the random requests carry
    logic [31:0] clock_ms;

    fsrc_pkg::out_item_t expected_commands[$];
    int                  mismatch_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    fan_speed_ramp_controller_unit #(
        .UPDATE_INTERVAL_MS(EVAL_INTERVAL_MS),
        .STALL_RPM         (STALL_LIMIT_RPM)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    // Linear ramp between threshold and end point, exact integer division.
    function automatic int ramp_speed(input int v, input int t, input int a);
        int span;
        int num;
        if (v < t) return 0;
        if (v >= a) return spd_max;
        span = a - t;
        if (span <= 0) return spd_max;
        num = v - t;
        if (spd_max >= spd_min) return spd_min + (num * (spd_max - spd_min)) / span;
        // inverted limits: the ramp falls from speed_min, truncated toward zero
        return spd_min - (num * (spd_min - spd_max)) / span;
    endfunction

    // Work out the fan command for one request; returns 0 when none is due.
    function automatic bit predict_fan_command(input fsrc_pkg::in_item_t req,
                                               output fsrc_pkg::out_item_t res);
        logic [31:0] elapsed;
        int          temp;
        int          hum;
        int          delta;
        int          st;
        int          sh;
        int          target;
        bit          favourable;
        res   = '0;
        st    = 0;
        sh    = 0;
        temp  = $signed(req.temperature);
        hum   = req.humidity;
        delta = $signed(req.temp_delta);
        if (req.func == fsrc_pkg::FUNC_OFF) begin
            target    = 0;
            res.cause = fsrc_pkg::CAUSE_MANUAL;
        end else if (req.func == fsrc_pkg::FUNC_ON) begin
            target    = (req.manual_speed > fsrc_pkg::MANUAL_CAP) ? fsrc_pkg::MANUAL_CAP
                                                                  : req.manual_speed;
            res.cause = fsrc_pkg::CAUSE_MANUAL;
        end else begin
            // both automatic codes; the timer wraps modulo 2^32
            elapsed = req.now_ms - last_eval_ms;
            if (elapsed < EVAL_INTERVAL_MS) return 0;
            last_eval_ms = req.now_ms;
            if (!req.recipe_active || !req.sensors_valid) begin
                target    = spd_safety;
                res.cause = fsrc_pkg::CAUSE_SAFETY;
            end else begin
                if (temp >= thr_temp) begin
                    // without an outside probe the delta always counts as favourable
                    favourable = req.has_external ? (delta > delta_floor) : 1'b1;
                    if (favourable) begin
                        st = ramp_speed(temp, thr_temp, alarm_temp);
                        res.temp_ramp_active = 1'b1;
                    end
                end
                if (hum >= thr_hum) sh = ramp_speed(hum, thr_hum, alarm_hum);
                target = (st > sh) ? st : sh;
                if (target < spd_min) target = spd_min;
                if (target > spd_max) target = spd_max;
                if (st > 0 && sh > 0)  res.cause = fsrc_pkg::CAUSE_COMBINED;
                else if (st > 0)       res.cause = fsrc_pkg::CAUSE_TEMP;
                else if (sh > 0)       res.cause = fsrc_pkg::CAUSE_HUM;
                else                   res.cause = fsrc_pkg::CAUSE_MINIMUM;
                res.speed_from_temp   = st[6:0];
                res.speed_from_hum    = sh[6:0];
                res.telemetry_updated = 1'b1;
            end
        end
        res.speed_percent = target[6:0];
        res.relay_on      = (target != 0);
        res.stalled       = (req.fan_rpm < STALL_LIMIT_RPM) && (target != 0);
        return 1;
    endfunction

    task automatic note_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) note_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Compare every accepted result beat with the oldest pending command.
    always @(posedge aclk) begin : result_check
        fsrc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_commands.size() == 0) begin
                note_error("result beat with no command pending");
            end else begin
                want = expected_commands.pop_front();
                check_field("speed_percent", m_item.speed_percent, want.speed_percent);
                check_field("relay_on", m_item.relay_on, want.relay_on);
                check_field("cause", m_item.cause, want.cause);
                check_field("stalled", m_item.stalled, want.stalled);
                check_field("speed_from_temp", m_item.speed_from_temp, want.speed_from_temp);
                check_field("speed_from_hum", m_item.speed_from_hum, want.speed_from_hum);
                check_field("temp_ramp_active", m_item.temp_ramp_active,
                            want.temp_ramp_active);
                check_field("telemetry_updated", m_item.telemetry_updated,
                            want.telemetry_updated);
            end
        end
    end

    // Receiver: drop ready at random, decided on the falling edge.
    initial begin
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Write one register; call on a falling edge, returns on a falling edge.
    task automatic write_setting(input fsrc_pkg::cfg_idx_t idx, input logic [11:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            fsrc_pkg::CFG_TEMP_THRESHOLD: thr_temp    = $signed(data);
            fsrc_pkg::CFG_TEMP_MAX_ALARM: alarm_temp  = $signed(data);
            fsrc_pkg::CFG_HUM_THRESHOLD:  thr_hum     = data[9:0];
            fsrc_pkg::CFG_HUM_MAX_ALARM:  alarm_hum   = data[9:0];
            fsrc_pkg::CFG_SPEED_MIN:      spd_min     = data[6:0];
            fsrc_pkg::CFG_SPEED_MAX:      spd_max     = data[6:0];
            fsrc_pkg::CFG_DELTA_MIN:      delta_floor = $signed(data);
            fsrc_pkg::CFG_SAFETY_SPEED:   spd_safety  = data[6:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all_settings(input logic [11:0] tt, input logic [11:0] ta,
                                      input logic [11:0] ht, input logic [11:0] ha,
                                      input logic [11:0] lo, input logic [11:0] hi,
                                      input logic [11:0] dm, input logic [11:0] sf);
        write_setting(fsrc_pkg::CFG_TEMP_THRESHOLD, tt);
        write_setting(fsrc_pkg::CFG_TEMP_MAX_ALARM, ta);
        write_setting(fsrc_pkg::CFG_HUM_THRESHOLD, ht);
        write_setting(fsrc_pkg::CFG_HUM_MAX_ALARM, ha);
        write_setting(fsrc_pkg::CFG_SPEED_MIN, lo);
        write_setting(fsrc_pkg::CFG_SPEED_MAX, hi);
        write_setting(fsrc_pkg::CFG_DELTA_MIN, dm);
        write_setting(fsrc_pkg::CFG_SAFETY_SPEED, sf);
    endtask

    // Send one request beat; call on a falling edge, returns on a falling edge.
    task automatic send_request(input fsrc_pkg::in_item_t req);
        fsrc_pkg::out_item_t res;
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_item  = req;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (predict_fan_command(req, res)) expected_commands.push_back(res);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Hold off until every pending command has come back and the block is quiet.
    task automatic wait_drained();
        while (expected_commands.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic fsrc_pkg::in_item_t make_request(input logic [1:0] fn,
                                                        input int manual,
                                                        input logic [31:0] now, input bit act,
                                                        input bit sv, input bit ext,
                                                        input int temp, input int hum,
                                                        input int delta, input int rpm);
        fsrc_pkg::in_item_t r;
        r.func          = fn;
        r.manual_speed  = manual[7:0];
        r.now_ms        = now;
        r.recipe_active = act;
        r.sensors_valid = sv;
        r.has_external  = ext;
        r.temperature   = temp[11:0];
        r.humidity      = hum[9:0];
        r.temp_delta    = delta[11:0];
        r.fan_rpm       = rpm[15:0];
        return r;
    endfunction

    // Random request, often steered around the current ramp windows.
    function automatic fsrc_pkg::in_item_t random_request();
        int          pick;
        int          span;
        logic [1:0]  fn;
        int          temp;
        int          hum;
        int          delta;
        int          rpm;
        pick = $urandom_range(99);
        fn   = (pick < 14) ? fsrc_pkg::FUNC_OFF : (pick < 28) ? fsrc_pkg::FUNC_ON :
               (pick < 93) ? FUNC_AUTO : FUNC_AUTO_ALT;
        pick = $urandom_range(99);
        if (pick < 76)      clock_ms += $urandom_range(9000, 5000);
        else if (pick < 88) clock_ms += $urandom_range(4999);
        else if (pick < 94) clock_ms = last_eval_ms + 32'd4999 + $urandom_range(1);
        else if (pick < 97) clock_ms = 32'hFFFF_FFFF - $urandom_range(6000);
        else                clock_ms = $urandom;
        span = (alarm_temp > thr_temp) ? alarm_temp - thr_temp : 200;
        pick = $urandom_range(99);
        if (pick < 45)      temp = thr_temp - 60 + $urandom_range(span + 120);
        else if (pick < 85) temp = $urandom_range(1650) - 400;
        else                temp = $urandom_range(4095);
        span = (alarm_hum > thr_hum) ? alarm_hum - thr_hum : 200;
        pick = $urandom_range(99);
        if (pick < 45)      hum = thr_hum - 60 + $urandom_range(span + 120);
        else if (pick < 85) hum = $urandom_range(1000);
        else                hum = $urandom_range(1023);
        pick = $urandom_range(99);
        if (pick < 50)      delta = delta_floor - 20 + $urandom_range(40);
        else if (pick < 85) delta = $urandom_range(3300) - 1650;
        else                delta = $urandom_range(4095);
        rpm = ($urandom_range(1) == 0) ? $urandom_range(600) : $urandom_range(65535);
        return make_request(fn, $urandom_range(255), clock_ms, $urandom_range(99) < 90,
                            $urandom_range(99) < 90, $urandom_range(1), temp, hum, delta,
                            rpm);
    endfunction

    // Fresh random settings: mostly sane windows, some inverted or out of range.
    task automatic randomise_settings();
        int pick;
        int tt;
        int ta;
        int ht;
        int ha;
        int lo;
        int hi;
        int dm;
        int sf;
        tt = $urandom_range(1650) - 400;
        ta = ($urandom_range(99) < 85) ? tt + $urandom_range(400, 1)
                                       : $urandom_range(1650) - 400;
        ht = $urandom_range(1000);
        ha = ($urandom_range(99) < 85) ? ht + $urandom_range(300, 1) : $urandom_range(1023);
        pick = $urandom_range(99);
        if (pick < 75) begin
            lo = $urandom_range(60);
            hi = $urandom_range(100, lo);
        end else if (pick < 90) begin
            lo = $urandom_range(100, 50);
            hi = $urandom_range(49);
        end else begin
            lo = $urandom_range(127);
            hi = $urandom_range(127);
        end
        dm = ($urandom_range(99) < 80) ? $urandom_range(400) - 200 : $urandom_range(4095);
        sf = $urandom_range(127);
        write_all_settings(tt[11:0], ta[11:0], ht[11:0], ha[11:0], lo[11:0], hi[11:0],
                           dm[11:0], sf[11:0]);
    endtask

    // Off and manual beats at the edges of the manual speed and the stall threshold.
    task automatic test_manual_modes();
        send_request(make_request(fsrc_pkg::FUNC_OFF, 255, 0, 1, 1, 1, 0, 0, 0, 0));
        send_request(make_request(fsrc_pkg::FUNC_ON, 0, 0, 1, 1, 1, 0, 0, 0, 65535));
        send_request(make_request(fsrc_pkg::FUNC_ON, 100, 0, 0, 0, 0, 0, 0, 0, 299));
        send_request(make_request(fsrc_pkg::FUNC_ON, 101, 0, 1, 1, 1, 0, 0, 0, 300));
        send_request(make_request(fsrc_pkg::FUNC_ON, 255, 0, 1, 1, 1, 0, 0, 0, 0));
    endtask

    // Update interval: too early after reset, exactly on time, and across the wrap.
    task automatic test_update_timer();
        send_request(make_request(FUNC_AUTO, 0, 32'd4999, 1, 1, 1, 300, 800, 21, 1000));
        send_request(make_request(FUNC_AUTO, 0, 32'd5000, 0, 1, 1, 300, 800, 21, 1000));
        send_request(make_request(FUNC_AUTO, 0, 32'd9999, 1, 1, 1, 300, 800, 21, 1000));
        // mode three acts as automatic
        send_request(make_request(FUNC_AUTO_ALT, 0, 32'd10000, 1, 1, 1, 300, 800, 21, 1000));
        send_request(make_request(FUNC_AUTO, 0, 32'hFFFF_FFFF, 1, 0, 1, 300, 800, 21, 100));
        send_request(make_request(FUNC_AUTO, 0, 32'h0000_1386, 1, 1, 1, 300, 800, 21, 100));
        send_request(make_request(FUNC_AUTO, 0, 32'h0000_1387, 1, 1, 1, 300, 800, 21, 100));
        clock_ms = 32'h0000_1387;
    endtask

    // Ramp paths under the reset settings.
    task automatic test_ramp_paths();
        // no outside probe: a hostile delta still lets the temperature ramp run
        clock_ms += EVAL_INTERVAL_MS;
        send_request(make_request(FUNC_AUTO, 0, clock_ms, 1, 1, 0, 340, 0, -1650, 1000));
        // delta equal to the floor is not favourable
        clock_ms += EVAL_INTERVAL_MS;
        send_request(make_request(FUNC_AUTO, 0, clock_ms, 1, 1, 1, 400, 950, 20, 1000));
        clock_ms += EVAL_INTERVAL_MS;
        send_request(make_request(FUNC_AUTO, 0, clock_ms, 1, 1, 1, 2047, 1023, 1650, 0));
        clock_ms += EVAL_INTERVAL_MS;
        send_request(make_request(FUNC_AUTO, 0, clock_ms, 1, 1, 1, -2048, 0, -2048, 65535));
        clock_ms += EVAL_INTERVAL_MS;
        send_request(make_request(FUNC_AUTO, 0, clock_ms, 0, 0, 1, 300, 800, 21, 0));
    endtask

    // speed_min above speed_max: the ramp falls, the final limit wins.
    task automatic test_inverted_limits();
        wait_drained();
        write_setting(fsrc_pkg::CFG_SPEED_MIN, 12'd90);
        write_setting(fsrc_pkg::CFG_SPEED_MAX, 12'd10);
        clock_ms += EVAL_INTERVAL_MS;
        send_request(make_request(FUNC_AUTO, 0, clock_ms, 1, 1, 0, 300, 0, 0, 500));
        clock_ms += EVAL_INTERVAL_MS;
        send_request(make_request(FUNC_AUTO, 0, clock_ms, 1, 1, 1, 0, 800, 0, 500));
    endtask

    // Every register at its all-ones and all-zero pattern, then the widest window.
    task automatic test_setting_extremes();
        wait_drained();
        write_all_settings(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                           12'hFFF);
        clock_ms += EVAL_INTERVAL_MS;
        send_request(make_request(FUNC_AUTO, 0, clock_ms, 1, 1, 1, 0, 1023, 0, 0));
        clock_ms += EVAL_INTERVAL_MS;
        send_request(make_request(FUNC_AUTO, 0, clock_ms, 1, 0, 1, 0, 1023, 0, 0));
        wait_drained();
        write_all_settings(12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
                           12'h000);
        clock_ms += EVAL_INTERVAL_MS;
        send_request(make_request(FUNC_AUTO, 0, clock_ms, 1, 1, 1, 0, 0, 0, 0));
        wait_drained();
        write_setting(fsrc_pkg::CFG_TEMP_THRESHOLD, 12'h800);
        write_setting(fsrc_pkg::CFG_TEMP_MAX_ALARM, 12'h7FF);
        write_setting(fsrc_pkg::CFG_SPEED_MAX, 12'd127);
        clock_ms += EVAL_INTERVAL_MS;
        send_request(make_request(FUNC_AUTO, 0, clock_ms, 1, 1, 0, 2046, 0, 0, 299));
    endtask

    // Random traffic in blocks, each block under fresh settings.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int blocks, input int per_block);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int b = 0; b < blocks; b++) begin
            wait_drained();
            randomise_settings();
            for (int i = 0; i < per_block; i++) begin
                // once per block now and then, hold the sender until all results are back
                if (i == per_block / 2 && $urandom_range(1) == 0) wait_drained();
                send_request(random_request());
            end
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_item         = '0;
        m_ready        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        send_idle_pct  = 19;
        recv_idle_pct  = 58;
        clock_ms       = '0;
        thr_temp       = 250;
        alarm_temp     = 350;
        thr_hum        = 700;
        alarm_hum      = 900;
        spd_min        = 20;
        spd_max        = 100;
        delta_floor    = 20;
        spd_safety     = 30;
        last_eval_ms   = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_manual_modes();
        test_update_timer();
        test_ramp_paths();
        test_inverted_limits();
        test_setting_extremes();
        test_random_traffic(19, 58, 4, 110);
        test_random_traffic(58, 19, 4, 110);
        test_random_traffic(0, 0, 4, 110);

        wait_drained();
        if (expected_commands.size() != 0) note_error("commands left pending at the end");
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
